FILE: rtl/rpfc_pkg.sv
// ============================================================================
// rpfc_pkg: shared definitions for the RGB pixel format converter
// Conversion mode codes, register map constants and channel expansion helpers.
// ============================================================================
`default_nettype none

package rpfc_pkg;

    // Conversion selected by the mode register
    typedef enum logic [3:0] {
        MODE_8332_TO_8888      = 4'd0,
        MODE_8888_TO_8332      = 4'd1,
        MODE_565_TO_ARGB8888   = 4'd2,
        MODE_565_TO_XRGB8888   = 4'd3,
        MODE_8888_TO_565       = 4'd4,
        MODE_1555_TO_8888      = 4'd5,
        MODE_8888_TO_1555      = 4'd6,
        MODE_4444_TO_8888      = 4'd7,
        MODE_8888_TO_4444      = 4'd8
    } mode_t;

    localparam int unsigned MODE_W   = 4;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // Register index, taken from paddr above the byte offset
    localparam logic REG_MODE = 1'b0;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_8332_TO_8888;

    // Channel widening with rounded constant multiplies
    function automatic logic [7:0] x1to8(input logic v);
        return {8{v}};
    endfunction

    function automatic logic [7:0] x2to8(input logic [1:0] v);
        return 8'(v) * 8'd85;
    endfunction

    function automatic logic [7:0] x3to8(input logic [2:0] v);
        logic [9:0] t;
        t = 10'(v) * 10'd146 + 10'd1;
        return t[9:2];
    endfunction

    function automatic logic [7:0] x4to8(input logic [3:0] v);
        return 8'(v) * 8'd17;
    endfunction

    function automatic logic [7:0] x5to8(input logic [4:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd527 + 14'd23;
        return t[13:6];
    endfunction

    function automatic logic [7:0] x6to8(input logic [5:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd259 + 14'd33;
        return t[13:6];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb_pixel_format_converter.sv
// ============================================================================
// rgb_pixel_format_converter: packed RGB pixel format converter
// Two-register pipeline: input register, conversion logic, result register.
// ============================================================================
// One pixel per transaction, one result per pixel, in order. Throughput is one
// pixel per clock while m_ready does not stall the result register. An accepted
// pixel passes the input register, the conversion logic and the result
// register, which drives m_valid; the result can be taken from there.
// The mode register (address 0) selects the conversion and must only be
// written while no pixel is in flight. 16-bit formats sit in the low half of
// the pixel word; 16-bit results have the upper half zero. Unused mode codes
// give a zero pixel. end_of_run passes through to last_out.
`default_nettype none

module rgb_pixel_format_converter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rpfc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rpfc_pkg::DATA_W-1:0]    pwdata,
    output logic      [rpfc_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    // Input pixel channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [rpfc_pkg::PIXEL_W-1:0]   s_pixel_in,
    input  wire logic                           s_end_of_run,
    // Result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [rpfc_pkg::PIXEL_W-1:0]   m_pixel_out,
    output logic                                m_last_out
);

    logic [rpfc_pkg::MODE_W-1:0]  mode_reg;
    logic                         in_valid_reg;
    logic [rpfc_pkg::PIXEL_W-1:0] in_pixel_reg;
    logic                         in_last_reg;
    logic                         out_valid_reg;
    logic [rpfc_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic                         out_last_reg;
    logic [rpfc_pkg::PIXEL_W-1:0] conv_pixel;
    logic                         cfg_write;
    logic                         mode_sel;
    logic                         advance;
    logic                         in_take;

    // APB decode
    assign pready    = 1'b1;
    assign mode_sel  = (paddr[2] == rpfc_pkg::REG_MODE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = mode_sel ? {{(rpfc_pkg::DATA_W - rpfc_pkg::MODE_W){1'b0}}, mode_reg}
                                : '0;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rpfc_pkg::MODE_RESET;
        end else if (cfg_write && mode_sel) begin
            mode_reg <= pwdata[rpfc_pkg::MODE_W-1:0];
        end
    end

    // Pipeline flow control
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_pixel_reg <= s_pixel_in;
            in_last_reg  <= s_end_of_run;
        end
    end

    rpfc_convert u_convert (
        .mode      (mode_reg),
        .pixel_in  (in_pixel_reg),
        .pixel_out (conv_pixel)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_pixel_reg <= conv_pixel;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pixel_reg;
    assign m_last_out  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/rpfc_convert.sv
// ============================================================================
// rpfc_convert: combinational pixel format conversion
// Widens channels with rounded expansions or narrows them by truncation.
// ============================================================================
`default_nettype none

module rpfc_convert (
    input  wire logic [rpfc_pkg::MODE_W-1:0]  mode,
    input  wire logic [rpfc_pkg::PIXEL_W-1:0] pixel_in,
    output logic      [rpfc_pkg::PIXEL_W-1:0] pixel_out
);

    logic [15:0] h;

    // 16-bit sources use the low half only
    assign h = pixel_in[15:0];

    // Per-mode conversion; unused codes give zero
    always_comb begin
        unique case (mode)
            rpfc_pkg::MODE_8332_TO_8888: begin
                pixel_out = {h[15:8], rpfc_pkg::x3to8(h[7:5]),
                             rpfc_pkg::x3to8(h[4:2]), rpfc_pkg::x2to8(h[1:0])};
            end
            rpfc_pkg::MODE_8888_TO_8332: begin
                pixel_out = {16'h0, pixel_in[31:24], pixel_in[23:21],
                             pixel_in[15:13], pixel_in[7:6]};
            end
            rpfc_pkg::MODE_565_TO_ARGB8888: begin
                pixel_out = {8'hFF, rpfc_pkg::x5to8(h[15:11]),
                             rpfc_pkg::x6to8(h[10:5]), rpfc_pkg::x5to8(h[4:0])};
            end
            rpfc_pkg::MODE_565_TO_XRGB8888: begin
                pixel_out = {8'h00, rpfc_pkg::x5to8(h[15:11]),
                             rpfc_pkg::x6to8(h[10:5]), rpfc_pkg::x5to8(h[4:0])};
            end
            rpfc_pkg::MODE_8888_TO_565: begin
                pixel_out = {16'h0, pixel_in[23:19], pixel_in[15:10], pixel_in[7:3]};
            end
            rpfc_pkg::MODE_1555_TO_8888: begin
                pixel_out = {rpfc_pkg::x1to8(h[15]), rpfc_pkg::x5to8(h[14:10]),
                             rpfc_pkg::x5to8(h[9:5]), rpfc_pkg::x5to8(h[4:0])};
            end
            rpfc_pkg::MODE_8888_TO_1555: begin
                pixel_out = {16'h0, pixel_in[31], pixel_in[23:19],
                             pixel_in[15:11], pixel_in[7:3]};
            end
            rpfc_pkg::MODE_4444_TO_8888: begin
                pixel_out = {rpfc_pkg::x4to8(h[15:12]), rpfc_pkg::x4to8(h[11:8]),
                             rpfc_pkg::x4to8(h[7:4]), rpfc_pkg::x4to8(h[3:0])};
            end
            rpfc_pkg::MODE_8888_TO_4444: begin
                pixel_out = {16'h0, pixel_in[31:28], pixel_in[23:20],
                             pixel_in[15:12], pixel_in[7:4]};
            end
            default: begin
                pixel_out = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/rpfc_checker.sv
// ============================================================================
// rpfc_checker: port-level checks for the pixel format converter
// Watches the top-level ports and is bound to every converter instance.
// ============================================================================
`default_nettype none

module rpfc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           psel,
    input wire logic                           pwrite,
    input wire logic [rpfc_pkg::DATA_W-1:0]    prdata,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [rpfc_pkg::PIXEL_W-1:0]   m_pixel_out,
    input wire logic                           m_last_out
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_last_out))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input backpressure only when a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    // An accepted pixel reaches the output unless the result channel blocks it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready |=> m_valid)
        else $error("accepted pixel did not reach the output");

    // Mode readback carries only the register bits
    a_prdata_width: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !pwrite |-> prdata[rpfc_pkg::DATA_W-1:rpfc_pkg::MODE_W] == '0)
        else $error("read data has bits above the mode field");

endmodule

bind rgb_pixel_format_converter rpfc_checker u_rpfc_checker (.*);

`default_nettype wire

FILE: tb/rgb_pixel_format_converter_test.sv
// ============================================================================
// rgb_pixel_format_converter_test: self-checking bench for the pixel converter
// Drives pixel transactions through every conversion mode and some unused
// codes, predicts each converted pixel in the bench and checks the results in
// order. Random stalls on both channels, one long result stall, and APB mode
// writes with read-back between phases.
// ============================================================================
`default_nettype none

module rgb_pixel_format_converter_test;

    import rpfc_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } pixel_item_t;

    localparam logic [ADDR_W-1:0] MODE_ADDR   = {REG_MODE, 2'b00};
    // Index 1 is not a register; writes there must be dropped
    localparam logic [ADDR_W-1:0] SPARE_ADDR  = 3'b100;
    localparam logic [MODE_W-1:0] UNUSED_MODE = 4'hF;
    localparam int PHASE_ITEMS      = 80;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 10;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [PIXEL_W-1:0]  s_pixel_in   = '0;
    logic                s_end_of_run = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [PIXEL_W-1:0]  m_pixel_out;
    logic                m_last_out;

    pixel_item_t         pixels_to_send[$];
    pixel_item_t         expected_pixels[$];
    logic [MODE_W-1:0]   cfg_mode        = MODE_RESET;
    logic                in_accepted     = 1'b0;
    logic                idle_en         = 1'b1;
    logic                want_long_hold  = 1'b0;
    logic                long_hold_taken = 1'b0;
    int                  src_gap         = 0;
    int                  sink_stall      = 0;
    int                  hold_count      = 0;
    int                  quiet_cycles    = 0;
    int                  error_count     = 0;

    rgb_pixel_format_converter i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .s_end_of_run (s_end_of_run),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_last_out   (m_last_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Channel widening, rounded
    function automatic logic [7:0] widen2(input logic [1:0] v);
        return 8'(int'(v) * 85);
    endfunction

    function automatic logic [7:0] widen3(input logic [2:0] v);
        return 8'((int'(v) * 146 + 1) >> 2);
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return 8'(int'(v) * 17);
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return 8'((int'(v) * 527 + 23) >> 6);
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return 8'((int'(v) * 259 + 33) >> 6);
    endfunction

    // Expected output pixel for one source pixel under a mode code
    function automatic logic [PIXEL_W-1:0] convert_pixel(input logic [MODE_W-1:0] m,
                                                         input logic [PIXEL_W-1:0] p);
        logic [15:0] h;
        logic [23:0] rgb565;
        h = p[15:0];
        rgb565 = {widen5(h[15:11]), widen6(h[10:5]), widen5(h[4:0])};
        case (m)
            MODE_8332_TO_8888:
                return {h[15:8], widen3(h[7:5]), widen3(h[4:2]), widen2(h[1:0])};
            MODE_8888_TO_8332:
                return {16'h0, p[31:24], p[23:21], p[15:13], p[7:6]};
            MODE_565_TO_ARGB8888:
                return {8'hFF, rgb565};
            MODE_565_TO_XRGB8888:
                return {8'h00, rgb565};
            MODE_8888_TO_565:
                return {16'h0, p[23:19], p[15:10], p[7:3]};
            MODE_1555_TO_8888:
                return {{8{h[15]}}, widen5(h[14:10]), widen5(h[9:5]), widen5(h[4:0])};
            MODE_8888_TO_1555:
                return {16'h0, p[31], p[23:19], p[15:11], p[7:3]};
            MODE_4444_TO_8888:
                return {widen4(h[15:12]), widen4(h[11:8]), widen4(h[7:4]), widen4(h[3:0])};
            MODE_8888_TO_4444:
                return {16'h0, p[31:28], p[23:20], p[15:12], p[7:4]};
            default:
                return '0;
        endcase
    endfunction

    // Source driver: holds each pixel until it is taken, random gaps between
    always @(negedge aclk) begin
        logic offer;
        offer = s_valid;
        if (s_valid && in_accepted) begin
            void'(pixels_to_send.pop_front());
            offer = 1'b0;
        end
        if (!offer) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pixels_to_send.size() != 0) begin
                if (idle_en && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 9);
                end else begin
                    offer = 1'b1;
                    s_pixel_in   <= pixels_to_send[0].pixel;
                    s_end_of_run <= pixels_to_send[0].last;
                end
            end
        end
        s_valid <= offer;
    end

    // Result sink: random stall bursts, plus one long hold-off on request
    always @(negedge aclk) begin
        if (want_long_hold && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_count = LONG_HOLD_CYCLES;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on input transactions, check on result transactions
    always @(posedge aclk) begin
        pixel_item_t want;
        in_accepted <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_pixels.push_back('{convert_pixel(cfg_mode, s_pixel_in),
                                            s_end_of_run});
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result pixel_out %08h last_out %0b",
                             $time, m_pixel_out, m_last_out);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_out !== want.pixel) begin
                        $display("%0t: pixel_out expected %08h, got %08h",
                                 $time, want.pixel, m_pixel_out);
                        error_count++;
                    end
                    if (m_last_out !== want.last) begin
                        $display("%0t: last_out expected %0b, got %0b",
                                 $time, want.last, m_last_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("rgb_pixel_format_converter test failed");
            $finish;
        end
    end

    // Wait until every queued pixel is sent and every result has arrived
    task automatic wait_for_idle();
        while (pixels_to_send.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(negedge aclk);
    endtask

    // APB write, then read the mode register back
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] got;
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == MODE_ADDR)
            cfg_mode = data[MODE_W-1:0];
        @(negedge aclk);
        penable = 1'b0; pwrite = 1'b0; paddr = MODE_ADDR;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        if (got !== DATA_W'(cfg_mode)) begin
            $display("%0t: mode read-back expected %08h, got %08h",
                     $time, DATA_W'(cfg_mode), got);
            error_count++;
        end
    endtask

    // Random runs of pixels, mostly closed by an end-of-run mark
    task automatic queue_random_runs(input int count);
        int run_len;
        logic [PIXEL_W-1:0] pix;
        run_len = $urandom_range(1, 16);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 15))
                0: pix = '0;
                1: pix = '1;
                2: pix = 32'h0000_FFFF;
                3: pix = 32'hFFFF_0000;
                default: pix = $urandom;
            endcase
            run_len--;
            if ($urandom_range(0, 19) == 0)
                pixels_to_send.push_back('{pix, 1'($urandom_range(0, 1))});
            else
                pixels_to_send.push_back('{pix, run_len == 0});
            if (run_len == 0)
                run_len = $urandom_range(1, 16);
        end
    endtask

    initial begin
        logic [MODE_W-1:0] directed_modes[10];
        logic [MODE_W-1:0] phase_modes[16];
        logic [MODE_W-1:0] tmp;
        int j;

        directed_modes = '{MODE_8332_TO_8888, MODE_8888_TO_8332, MODE_565_TO_ARGB8888,
                           MODE_565_TO_XRGB8888, MODE_8888_TO_565, MODE_1555_TO_8888,
                           MODE_8888_TO_1555, MODE_4444_TO_8888, MODE_8888_TO_4444,
                           UNUSED_MODE};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset mode is in effect before any write
        pixels_to_send.push_back('{32'hFFFF_FFFF, 1'b1});
        wait_for_idle();

        // Directed: extremes in every mode, upper register bits set on some writes
        foreach (directed_modes[k]) begin
            apb_write(MODE_ADDR, {$urandom_range(0, 1) ? 28'hFFF_FFFF : 28'h0,
                                  directed_modes[k]});
            pixels_to_send.push_back('{32'h0000_0000, 1'b0});
            pixels_to_send.push_back('{32'hFFFF_FFFF, 1'b1});
            wait_for_idle();
        end

        // Write to a non-register index must leave the mode alone
        apb_write(MODE_ADDR, 32'hA5A5_A5A3);
        apb_write(SPARE_ADDR, 32'h0000_0007);
        pixels_to_send.push_back('{32'hFFFF_0000, 1'b0});
        pixels_to_send.push_back('{32'h0000_F81F, 1'b1});
        wait_for_idle();

        // Random phases over all sixteen codes in shuffled order
        for (int k = 0; k < 16; k++)
            phase_modes[k] = MODE_W'(k);
        for (int k = 15; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = phase_modes[k];
            phase_modes[k] = phase_modes[j];
            phase_modes[j] = tmp;
        end
        foreach (phase_modes[k]) begin
            idle_en = (k < 14) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                apb_write(SPARE_ADDR, $urandom);
            apb_write(MODE_ADDR, {28'($urandom), phase_modes[k]});
            if (k == 2)
                want_long_hold = 1'b1;
            queue_random_runs(PHASE_ITEMS);
            wait_for_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("rgb_pixel_format_converter test passed");
        else
            $display("rgb_pixel_format_converter test failed");
        $finish;
    end

endmodule

`default_nettype wire
